/* rtl/core/triangle_circumcenter_assert.svh */
// assertion macros for the triangle circumcenter block
`ifndef TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`define TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/tcc_pkg.sv */
// shared constants, payload types and datapath widths of the circumcenter block
package tcc_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned OUT_BITS   = 40;
  localparam int unsigned AREA_BITS  = 34;

  // internal widths, all exact
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PROD_W  = 2 * COORD_BITS + 1;
  localparam int unsigned D_W     = 2 * COORD_BITS + 3;
  localparam int unsigned NORM_W  = 2 * COORD_BITS + 2;
  localparam int unsigned NDIFF_W = 2 * COORD_BITS + 3;
  localparam int unsigned TERM_W  = 3 * COORD_BITS + 3;
  localparam int unsigned NUM_W   = 3 * COORD_BITS + 5;
  localparam int unsigned QUO_W   = NUM_W + FRAC_BITS;
  localparam int unsigned DEN_W   = D_W + 1;

  // configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 64;
  localparam logic IDX_MIN_TWICE_AREA = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } tcc_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic [AREA_BITS-1:0]       twice_area;
    logic                       degenerate;
    logic                       saturated;
  } tcc_out_t;

  // one divider lane: numerator bits shift out on top, quotient bits in at the bottom
  typedef struct packed {
    logic [QUO_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic             neg;
  } tcc_lane_t;

  // side band that travels with each transaction through the divider
  typedef struct packed {
    logic [DEN_W-1:0]     den;
    logic [AREA_BITS-1:0] twice_area;
    logic                 degen;
  } tcc_side_t;

endpackage

/* rtl/core/tcc_front.sv */
// front pipeline: determinant, squared norms and center numerators
module tcc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  tcc_pkg::tcc_in_t              in_data_i,
  input  logic [tcc_pkg::AREA_BITS-1:0] min_area_i,
  output logic                          valid_o,
  output tcc_pkg::tcc_lane_t            lane_x_o,
  output tcc_pkg::tcc_lane_t            lane_y_o,
  output tcc_pkg::tcc_side_t            side_o
);
  import tcc_pkg::*;

  localparam int unsigned CMP_W = D_W + AREA_BITS;
  localparam logic [CMP_W-1:0] AREA_MAX = CMP_W'({AREA_BITS{1'b1}});

  logic [6:0] valid_q;

  // stage 1
  tcc_in_t c1_q;
  logic signed [DIFF_W-1:0] dy_bc_q, dy_ca_q, dy_ab_q;
  // stage 2
  tcc_in_t c2_q;
  logic signed [PROD_W-1:0] pd_a_q, pd_b_q, pd_c_q;
  logic signed [PROD_W-1:0] sq_ax_q, sq_ay_q, sq_bx_q, sq_by_q, sq_cx_q, sq_cy_q;
  // stage 3
  tcc_in_t c3_q;
  logic signed [D_W-1:0]    d_q;
  logic signed [NORM_W-1:0] na_q, nb_q, nc_q;
  // stage 4
  tcc_in_t c4_q;
  logic [D_W-1:0]            area4_q;
  logic                      dneg4_q;
  logic signed [NDIFF_W-1:0] nbc_q, nca_q, nab_q;
  // stage 5
  logic [D_W-1:0]           area5_q;
  logic                     dneg5_q;
  logic signed [TERM_W-1:0] ty_a_q, ty_b_q, ty_c_q, tx_a_q, tx_b_q, tx_c_q;
  // stage 6
  logic [D_W-1:0]          area6_q;
  logic                    dneg6_q;
  logic                    degen6_q;
  logic signed [NUM_W-1:0] nx_q, ny_q;
  // stage 7
  tcc_lane_t lane_x_q, lane_y_q;
  tcc_side_t side_q;

  logic [NUM_W-1:0] mag_x, mag_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[5:0], in_valid_i};
    end
  end

  always_comb begin
    mag_x = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
    mag_y = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q    <= in_data_i;
      dy_bc_q <= DIFF_W'(in_data_i.by_coord) - DIFF_W'(in_data_i.cy);
      dy_ca_q <= DIFF_W'(in_data_i.cy) - DIFF_W'(in_data_i.ay);
      dy_ab_q <= DIFF_W'(in_data_i.ay) - DIFF_W'(in_data_i.by_coord);

      c2_q    <= c1_q;
      pd_a_q  <= PROD_W'(c1_q.ax) * PROD_W'(dy_bc_q);
      pd_b_q  <= PROD_W'(c1_q.bx) * PROD_W'(dy_ca_q);
      pd_c_q  <= PROD_W'(c1_q.cx) * PROD_W'(dy_ab_q);
      sq_ax_q <= PROD_W'(c1_q.ax) * PROD_W'(c1_q.ax);
      sq_ay_q <= PROD_W'(c1_q.ay) * PROD_W'(c1_q.ay);
      sq_bx_q <= PROD_W'(c1_q.bx) * PROD_W'(c1_q.bx);
      sq_by_q <= PROD_W'(c1_q.by_coord) * PROD_W'(c1_q.by_coord);
      sq_cx_q <= PROD_W'(c1_q.cx) * PROD_W'(c1_q.cx);
      sq_cy_q <= PROD_W'(c1_q.cy) * PROD_W'(c1_q.cy);

      c3_q <= c2_q;
      d_q  <= D_W'(pd_a_q) + D_W'(pd_b_q) + D_W'(pd_c_q);
      na_q <= NORM_W'(sq_ax_q) + NORM_W'(sq_ay_q);
      nb_q <= NORM_W'(sq_bx_q) + NORM_W'(sq_by_q);
      nc_q <= NORM_W'(sq_cx_q) + NORM_W'(sq_cy_q);

      c4_q    <= c3_q;
      area4_q <= d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
      dneg4_q <= d_q[D_W-1];
      nbc_q   <= NDIFF_W'(nb_q) - NDIFF_W'(nc_q);
      nca_q   <= NDIFF_W'(nc_q) - NDIFF_W'(na_q);
      nab_q   <= NDIFF_W'(na_q) - NDIFF_W'(nb_q);

      area5_q <= area4_q;
      dneg5_q <= dneg4_q;
      ty_a_q  <= TERM_W'(c4_q.ay) * TERM_W'(nbc_q);
      ty_b_q  <= TERM_W'(c4_q.by_coord) * TERM_W'(nca_q);
      ty_c_q  <= TERM_W'(c4_q.cy) * TERM_W'(nab_q);
      tx_a_q  <= TERM_W'(c4_q.ax) * TERM_W'(nbc_q);
      tx_b_q  <= TERM_W'(c4_q.bx) * TERM_W'(nca_q);
      tx_c_q  <= TERM_W'(c4_q.cx) * TERM_W'(nab_q);

      area6_q  <= area5_q;
      dneg6_q  <= dneg5_q;
      degen6_q <= CMP_W'(area5_q) <= CMP_W'(min_area_i);
      nx_q     <= NUM_W'(ty_a_q) + NUM_W'(ty_b_q) + NUM_W'(ty_c_q);
      ny_q     <= NUM_W'(tx_a_q) + NUM_W'(tx_b_q) + NUM_W'(tx_c_q);

      // x takes the negated numerator, so its sign is that of nx flipped
      lane_x_q.nq  <= QUO_W'(mag_x) << FRAC_BITS;
      lane_x_q.rem <= '0;
      lane_x_q.neg <= (!nx_q[NUM_W-1] && (nx_q != '0)) ^ dneg6_q;
      lane_y_q.nq  <= QUO_W'(mag_y) << FRAC_BITS;
      lane_y_q.rem <= '0;
      lane_y_q.neg <= ny_q[NUM_W-1] ^ dneg6_q;
      side_q.den   <= {area6_q, 1'b0};
      side_q.twice_area <= (CMP_W'(area6_q) > AREA_MAX) ? AREA_BITS'(AREA_MAX)
                                                          : AREA_BITS'(area6_q);
      side_q.degen <= degen6_q;
    end
  end

  assign valid_o  = valid_q[6];
  assign lane_x_o = lane_x_q;
  assign lane_y_o = lane_y_q;
  assign side_o   = side_q;

endmodule

/* rtl/core/tcc_div_cell.sv */
// one restoring division step for both center lanes
module tcc_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tcc_pkg::tcc_lane_t lane_x_i,
  input  tcc_pkg::tcc_lane_t lane_y_i,
  input  tcc_pkg::tcc_side_t side_i,
  output logic               valid_o,
  output tcc_pkg::tcc_lane_t lane_x_o,
  output tcc_pkg::tcc_lane_t lane_y_o,
  output tcc_pkg::tcc_side_t side_o
);
  import tcc_pkg::*;

  function automatic tcc_lane_t div_step(tcc_lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] sh;
    logic           ge;
    tcc_lane_t      r;
    sh    = {l.rem, l.nq[QUO_W-1]};
    ge    = sh >= {1'b0, den};
    r.rem = ge ? DEN_W'(sh - {1'b0, den}) : DEN_W'(sh);
    r.nq  = {l.nq[QUO_W-2:0], ge};
    r.neg = l.neg;
    return r;
  endfunction

  logic      valid_q;
  tcc_lane_t lane_x_q, lane_y_q;
  tcc_side_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_x_q <= div_step(lane_x_i, side_i.den);
      lane_y_q <= div_step(lane_y_i, side_i.den);
      side_q   <= side_i;
    end
  end

  assign valid_o  = valid_q;
  assign lane_x_o = lane_x_q;
  assign lane_y_o = lane_y_q;
  assign side_o   = side_q;

endmodule

/* rtl/core/tcc_back.sv */
// result rounding, saturation and output register with skid slot
`include "triangle_circumcenter_assert.svh"
module tcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tcc_pkg::tcc_lane_t lane_x_i,
  input  tcc_pkg::tcc_lane_t lane_y_i,
  input  tcc_pkg::tcc_side_t side_i,
  output logic               en_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcc_pkg::tcc_out_t  out_data_o
);
  import tcc_pkg::*;

  localparam int unsigned SAT_W = QUO_W + OUT_BITS;
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  // returns {clipped, value}
  function automatic logic [OUT_BITS:0] fmt(tcc_lane_t l);
    logic [SAT_W-1:0] q;
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] mag;
    logic [SAT_W-1:0] val;
    logic             sat;
    q   = SAT_W'(l.nq);
    lim = l.neg ? (SAT_W'(1) << (OUT_BITS - 1)) : ((SAT_W'(1) << (OUT_BITS - 1)) - SAT_W'(1));
    sat = q > lim;
    mag = sat ? lim : q;
    val = l.neg ? -mag : mag;
    return {sat, OUT_BITS'(val)};
  endfunction

  logic [OUT_BITS:0] fx, fy;
  tcc_out_t res;
  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  tcc_out_t out_q, out_d, skid_q, skid_d;
  logic     out_take;

  always_comb begin
    fx = fmt(lane_x_i);
    fy = fmt(lane_y_i);
    res.twice_area = side_i.twice_area;
    res.degenerate = side_i.degen;
    if (side_i.degen) begin
      res.center_x  = '0;
      res.center_y  = '0;
      res.saturated = 1'b0;
    end else begin
      res.center_x  = fx[OUT_BITS-1:0];
      res.center_y  = fy[OUT_BITS-1:0];
      res.saturated = fx[OUT_BITS] | fy[OUT_BITS];
    end
  end

  assign out_take = out_valid_q & out_ready_i;
  assign en_o     = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_d = valid_i;
      out_d       = res;
    end else if (valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCC_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, out_valid_q && out_q.degenerate, out_q.center_x == '0 && out_q.center_y == '0 && !out_q.saturated, "degenerate result with nonzero center")
  `TCC_ASSERT_IMPL(a_skid_has_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid slot full while output empty")
  `TCC_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i), "skid slot filled without a stall")
  `TCC_ASSERT_IMPL(a_sat_at_limit, clk_i, rst_ni, out_valid_q && out_q.saturated, out_q.center_x == OUT_MAX || out_q.center_x == OUT_MIN || out_q.center_y == OUT_MAX || out_q.center_y == OUT_MIN, "saturated flag without a clipped center")

endmodule

/* rtl/core/triangle_circumcenter.sv */
// top level of the triangle circumcenter and twice-area unit
// Takes one triangle per cycle and returns its twice-area |D| and circumcenter
// in signed Q23.16, rounded toward zero and clipped to 40 bits (saturated flag).
// A triangle whose twice-area is at most min_twice_area (APB register at byte
// address 0, 64-bit data) is degenerate and gets a zero center. The pipeline
// has seven front stages (differences, products, determinant and norms,
// norm differences, numerator products, numerator sums and threshold compare,
// magnitude and scaling), then a row of 69 division cells that produce one
// quotient bit each for both coordinates, then the output register. Throughput
// is one transaction per cycle; the whole pipeline holds only when the output
// register and its one-entry skid slot are both full.
module triangle_circumcenter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tcc_pkg::tcc_in_t            in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcc_pkg::tcc_out_t           out_data_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::CFG_AW-1:0]  paddr,
  input  logic [tcc_pkg::CFG_DW-1:0]  pwdata,
  output logic [tcc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import tcc_pkg::*;

  // register index sits above the 8-byte word offset
  logic reg_idx;
  logic [AREA_BITS-1:0] min_area_q;

  // pipeline enable, low only when the output side is full
  logic en;

  // front to divider
  logic      front_valid;
  tcc_lane_t front_x, front_y;
  tcc_side_t front_side;

  // divider chain, entry 0 fed by the front
  logic      chain_valid [QUO_W+1];
  tcc_lane_t chain_x     [QUO_W+1];
  tcc_lane_t chain_y     [QUO_W+1];
  tcc_side_t chain_side  [QUO_W+1];

  assign reg_idx = paddr[3];
  assign pready  = 1'b1;

  // threshold register, written in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= '0;
    end else if (psel && penable && pwrite && (reg_idx == IDX_MIN_TWICE_AREA)) begin
      min_area_q <= pwdata[AREA_BITS-1:0];
    end
  end

  assign prdata = (reg_idx == IDX_MIN_TWICE_AREA) ? CFG_DW'(min_area_q) : '0;

  // ready is a register-driven signal, no path from out_ready_i
  assign in_ready_o = en;

  tcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .min_area_i (min_area_q),
    .valid_o    (front_valid),
    .lane_x_o   (front_x),
    .lane_y_o   (front_y),
    .side_o     (front_side)
  );

  assign chain_valid[0] = front_valid;
  assign chain_x[0]     = front_x;
  assign chain_y[0]     = front_y;
  assign chain_side[0]  = front_side;

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    tcc_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (chain_valid[k]),
      .lane_x_i (chain_x[k]),
      .lane_y_i (chain_y[k]),
      .side_i   (chain_side[k]),
      .valid_o  (chain_valid[k+1]),
      .lane_x_o (chain_x[k+1]),
      .lane_y_o (chain_y[k+1]),
      .side_o   (chain_side[k+1])
    );
  end

  // clipping, degenerate override and output buffering
  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[QUO_W]),
    .lane_x_i    (chain_x[QUO_W]),
    .lane_y_i    (chain_y[QUO_W]),
    .side_i      (chain_side[QUO_W]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/triangle_circumcenter_tb.sv */
// testbench for the triangle circumcenter unit: directed table plus random triangles
module triangle_circumcenter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  localparam int unsigned LATENCY   = 77;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned N_RANDOM  = 1100;
  localparam logic [33:0] AREA_MAX  = 34'h3_FFFF_FFFF;

  typedef enum int {CHK_PREDICT, CHK_TYPED} chk_mode_e;

  // one row of the directed table
  typedef struct {
    tcc_in_t   tri_in;
    chk_mode_e mode;
    tcc_out_t  typed;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  tcc_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  tcc_out_t out_data_o;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // predictor copy of the register
  logic [33:0] min_area_q;

  tcc_out_t expected_centers[$];
  int       errors;
  int       n_checked;
  int       n_sat;
  int       n_degen;
  int       idle_in_pct;
  int       idle_out_pct;
  bit       hold_off;
  int       quiet_cycles;
  bit       timed_out;

  triangle_circumcenter uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // quotient of num*2^FRAC by den, toward zero, clipped to 40 bits
  function automatic logic signed [39:0] scale_divide(logic signed [127:0] num,
                                                      logic signed [63:0] den,
                                                      ref bit clipped);
    logic        neg;
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] quo;
    logic [127:0] lim;
    neg   = num[127] ^ den[63];
    mag_n = num[127] ? -num : num;
    mag_d = den[63] ? 128'(-den) : 128'(den);
    quo   = (mag_n << FRAC_BITS) / mag_d;
    lim   = neg ? (128'd1 << 39) : ((128'd1 << 39) - 1);
    if (quo > lim) begin
      clipped = 1'b1;
      quo = lim;
    end
    return neg ? -quo[39:0] : quo[39:0];
  endfunction

  function automatic tcc_out_t predict_center(tcc_in_t t);
    logic signed [127:0] ax, ay, bx, by, cx, cy, d, na, nb, nc, nx, ny;
    logic [127:0] area;
    tcc_out_t r;
    bit clipped;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by_coord; cx = t.cx; cy = t.cy;
    d = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
    area = d[127] ? -d : d;
    r = '0;
    clipped = 1'b0;
    r.degenerate = (area <= 128'(min_area_q));
    r.twice_area = (area > 128'(AREA_MAX)) ? AREA_MAX : area[33:0];
    if (!r.degenerate) begin
      na = ax * ax + ay * ay;
      nb = bx * bx + by * by;
      nc = cx * cx + cy * cy;
      nx = ay * (nb - nc) + by * (nc - na) + cy * (na - nb);
      ny = ax * (nb - nc) + bx * (nc - na) + cx * (na - nb);
      r.center_x = scale_divide(-nx, 64'(2 * d), clipped);
      r.center_y = scale_divide(ny, 64'(2 * d), clipped);
    end
    r.saturated = clipped;
    return r;
  endfunction

  // apb write: setup cycle then access cycle
  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == CFG_AW'(0)) min_area_q = val[33:0];
  endtask

  // drive one triangle; valid stays up across back-to-back transactions
  task automatic send_triangle(tcc_in_t t, bit typed, tcc_out_t typed_val);
    if (idle_in_pct > 0) begin
      while ($urandom_range(99) < idle_in_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    expected_centers.insert(expected_centers.size(), typed ? typed_val : predict_center(t));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    while (expected_centers.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord(int spread);
    case (spread)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7FFF - 16'($urandom_range(3))
                                  : 16'sh8000 + 16'($urandom_range(3));
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic tcc_in_t rand_triangle();
    tcc_in_t t;
    int s;
    s = $urandom_range(9);
    s = (s < 5) ? 0 : (s < 7) ? 3 : (s < 9) ? 1 : 2;
    t.ax = rand_coord(s); t.ay = rand_coord(s);
    t.bx = rand_coord(s); t.by_coord = rand_coord(s);
    t.cx = rand_coord(s); t.cy = rand_coord(s);
    // nearly collinear points push the center far out and into clipping
    if ($urandom_range(7) == 0) begin
      t.cx = t.bx + (t.bx - t.ax) + 16'($urandom_range(1));
      t.cy = t.by_coord + (t.by_coord - t.ay);
    end
    return t;
  endfunction

  // result side: random stalls plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off)
        out_ready_i <= 1'b0;
      else
        out_ready_i <= ($urandom_range(99) >= idle_out_pct);
      @(posedge clk_i);
    end
  end

  // checker: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_centers.size() == 0) begin
        $display("%0t unexpected result %p", $realtime, out_data_o);
        errors++;
      end else begin
        tcc_out_t e;
        e = expected_centers.pop_front();
        n_checked++;
        if (e.saturated) n_sat++;
        if (e.degenerate) n_degen++;
        if (e.center_x !== out_data_o.center_x)
          $display("%0t center_x expected %0d got %0d", $realtime, e.center_x,
                   out_data_o.center_x);
        if (e.center_y !== out_data_o.center_y)
          $display("%0t center_y expected %0d got %0d", $realtime, e.center_y,
                   out_data_o.center_y);
        if (e.twice_area !== out_data_o.twice_area)
          $display("%0t twice_area expected %0d got %0d", $realtime, e.twice_area,
                   out_data_o.twice_area);
        if (e.degenerate !== out_data_o.degenerate)
          $display("%0t degenerate expected %0b got %0b", $realtime, e.degenerate,
                   out_data_o.degenerate);
        if (e.saturated !== out_data_o.saturated)
          $display("%0t saturated expected %0b got %0b", $realtime, e.saturated,
                   out_data_o.saturated);
        if (e !== out_data_o) errors++;
      end
    end
  end

  // watchdog: cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else if (expected_centers.size() != 0 || in_valid_i)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_MAX && !timed_out) begin
      timed_out <= 1'b1;
      $display("triangle_circumcenter: mismatch");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic signed [15:0] ax, logic signed [15:0] ay,
                                    logic signed [15:0] bx, logic signed [15:0] by,
                                    logic signed [15:0] cx, logic signed [15:0] cy,
                                    chk_mode_e mode, tcc_out_t typed);
    stim_row_t r;
    r.tri_in = '{ax, ay, bx, by, cx, cy};
    r.mode = mode;
    r.typed = typed;
    return r;
  endfunction

  initial begin
    tcc_out_t z;
    tcc_out_t deg0;
    logic signed [15:0] mx, mn;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    min_area_q = '0;
    errors = 0; n_checked = 0; n_sat = 0; n_degen = 0;
    idle_in_pct = 0; idle_out_pct = 0; hold_off = 1'b0;
    quiet_cycles = 0; timed_out = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mx = 16'sh7FFF; mn = 16'sh8000;
    z = '0;
    deg0 = '0; deg0.degenerate = 1'b1;
    // all points equal, collinear, after reset: zero area is degenerate
    dir_rows.insert(dir_rows.size(), row(0, 0, 0, 0, 0, 0, CHK_TYPED, deg0));
    dir_rows.insert(dir_rows.size(), row(mn, mn, mn, mn, mn, mn, CHK_TYPED, deg0));
    dir_rows.insert(dir_rows.size(), row(1, 1, 2, 2, 3, 3, CHK_TYPED, deg0));
    // right triangle: D = 4, center (1,1)
    z.twice_area = 34'd4; z.center_x = 40'sh1_0000; z.center_y = 40'sh1_0000;
    dir_rows.insert(dir_rows.size(), row(0, 0, 2, 0, 0, 2, CHK_TYPED, z));
    // smallest area, extremes of every field
    dir_rows.insert(dir_rows.size(), row(0, 0, 1, 0, 0, 1, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(mn, mn, mx, mn, mn, mx, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(mx, mx, mn, mx, mx, mn, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(mn, mx, mx, mn, mx, mx, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(-1, -1, mx, mn, mn, mx, CHK_PREDICT, z));
    // nearly collinear, wide spread: center clips (the last row is a small ordinary triangle)
    dir_rows.insert(dir_rows.size(), row(mn, mn, 0, 0, mx, mx - 1, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(mx, mn, 0, 0, mn, mx - 1, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(mn, 0, 0, 1, mx, 0, CHK_PREDICT, z));
    dir_rows.insert(dir_rows.size(), row(-5, 7, 13, -2, 100, 99, CHK_PREDICT, z));
    foreach (dir_rows[i])
      send_triangle(dir_rows[i].tri_in, dir_rows[i].mode == CHK_TYPED, dir_rows[i].typed);
    end_burst();

    // threshold at the top of its range: every triangle degenerate
    write_reg(CFG_AW'(0), 64'h3_FFFF_FFFF);
    // unused register index is ignored
    write_reg(CFG_AW'(8), 64'd12345);
    send_triangle('{mn, mn, mx, mn, mn, mx}, 1'b0, z);
    for (int i = 0; i < 8; i++) send_triangle(rand_triangle(), 1'b0, z);
    end_burst();

    // threshold just below an exact area, then at it
    write_reg(CFG_AW'(0), 64'd3);
    send_triangle('{0, 0, 2, 0, 0, 2}, 1'b0, z);
    end_burst();
    write_reg(CFG_AW'(0), 64'd4);
    send_triangle('{0, 0, 2, 0, 0, 2}, 1'b0, z);
    end_burst();

    // random part in three idling phases, threshold changed between phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct  = (ph == 0) ? 20 : (ph == 1) ? 74 : 0;
      idle_out_pct = (ph == 0) ? 74 : (ph == 1) ? 20 : 0;
      write_reg(CFG_AW'(0), (ph == 0) ? 64'd0 : (ph == 1) ? 64'($urandom_range(1 << 20))
                                      : 64'd1000);
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        if (ph == 2 && i == 20) begin
          // long receiver hold-off while triangles keep coming
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_triangle(rand_triangle(), 1'b0, z);
      end
      end_burst();
    end

    if (expected_centers.size() != 0) begin
      $display("%0t %0d results never arrived", $realtime, expected_centers.size());
      errors++;
    end
    $display("checked %0d triangles: %0d degenerate, %0d with a clipped center",
             n_checked, n_degen, n_sat);
    $display("threshold swept from zero to full range, receiver stalls and hold-off applied");
    if (errors == 0)
      $display("triangle_circumcenter: match");
    else
      $display("triangle_circumcenter: mismatch");
    $finish;
  end
endmodule
